/* hw/rtl/byte_ring_fifo_burst_core_assert.svh */
// assertion macros for the burst byte ring
`ifndef BYTE_RING_FIFO_BURST_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_BURST_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define BRF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("brf assertion failed");
// expression must never be true outside reset
`define BRF_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("brf forbidden condition seen");
`else
`define BRF_ASSERT(lbl, clk, rstn, prop)
`define BRF_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* hw/rtl/brf_pkg.sv */
package brf_pkg;

  localparam int DEPTH     = 256;
  localparam int MAX_BURST = 8;
  localparam int NUM_LANES = 8;
  localparam int LANE_W    = $clog2(NUM_LANES);
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int BANK_D    = DEPTH / NUM_LANES;
  localparam int SIZE_W    = 9;
  localparam int BCNT_W    = 4;
  localparam int DATA_W    = 64;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  // one contiguous, non-wrapping run of slots
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] base;
    logic [BCNT_W-1:0] len;
    logic [LANE_W-1:0] off;
  } brf_seg_t;

  typedef struct packed {
    logic              valid;
    logic [LANE_W-1:0] idx;
    logic [7:0]        data;
  } brf_rd_t;

  function automatic logic [CNT_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/brf_ram.sv */
module brf_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/brf_lane.sv */
module brf_lane import brf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LANE_W-1:0] lane_id_i,
  input  brf_seg_t          seg_i,
  input  logic [DATA_W-1:0] data_i,
  output brf_rd_t           rd_o
);

  logic [LANE_W-1:0] delta;
  logic              hit;
  logic [ADDR_W-1:0] slot;
  logic [LANE_W-1:0] byte_idx;
  logic [7:0]        wbyte;
  logic [7:0]        rbyte;
  logic              rv_q;
  logic [LANE_W-1:0] ridx_q;

  // bank holds every slot whose low bits equal the lane number
  assign delta    = lane_id_i - seg_i.base[LANE_W-1:0];
  assign hit      = BCNT_W'(delta) < seg_i.len;
  assign slot     = seg_i.base + ADDR_W'(delta);
  assign byte_idx = seg_i.off + delta;
  assign wbyte    = data_i[8*byte_idx +: 8];

  brf_ram #(
    .Width (8),
    .Depth (BANK_D)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (seg_i.wr && hit),
    .addr_i  (slot[ADDR_W-1:LANE_W]),
    .wdata_i (wbyte),
    .rdata_o (rbyte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= seg_i.rd && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= byte_idx;
  end

  assign rd_o.valid = rv_q;
  assign rd_o.idx   = ridx_q;
  assign rd_o.data  = rbyte;

endmodule

/* hw/rtl/brf_merge.sv */
module brf_merge import brf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     clr_i,
  input  brf_rd_t [NUM_LANES-1:0]  rd_i,
  output logic [DATA_W-1:0]        data_o
);

  logic [DATA_W-1:0] dout_q;
  logic [DATA_W-1:0] dout_d;
  logic [DATA_W-1:0] gathered;

  // route each lane's byte to its place in the burst
  always_comb begin
    gathered = '0;
    for (int j = 0; j < MAX_BURST; j++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (rd_i[l].valid && (rd_i[l].idx == LANE_W'(j))) begin
          gathered[8*j +: 8] = gathered[8*j +: 8] | rd_i[l].data;
        end
      end
    end
  end

  assign dout_d = clr_i ? '0 : (dout_q | gathered);

  always_ff @(posedge clk_i) begin
    dout_q <= dout_d;
  end

  assign data_o = dout_q;

endmodule

/* hw/rtl/byte_ring_fifo_burst_core.sv */
// burst byte ring: flush, refused command: result strobe in the cycle after start
// put or get: states SEG_A, SEG_B (only when the burst wraps at ring_size), DRAIN, then RESP
// (SEG_A and SEG_B each present one contiguous run to the 8 byte-lane banks; DRAIN waits for read data)
// busy stays high until the result cycle ends; the receiver cannot stall results
// reset: pointers and fill count cleared, ring_size 256; slot contents undefined
`include "byte_ring_fifo_burst_core_assert.svh"

module byte_ring_fifo_burst_core import brf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic [BCNT_W-1:0] byte_count_i,
  input  logic [DATA_W-1:0] data_in_i,
  // result channel
  output logic              result_valid_o,
  output logic              accepted_o,
  output logic [BCNT_W-1:0] moved_count_o,
  output logic [DATA_W-1:0] data_out_o,
  output logic [SIZE_W-1:0] used_bytes_o,
  output logic [SIZE_W-1:0] free_bytes_o,
  output logic              is_empty_o,
  output logic              is_full_o,
  // ring size register
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SEG_A = 5'b00010,
    ST_SEG_B = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // ring state
  logic [CNT_W-1:0]  size_q, size_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;

  // per-transaction registers
  logic              is_wr_q, is_wr_d;
  logic              is_rd_q, is_rd_d;
  logic [ADDR_W-1:0] seg_base_q, seg_base_d;
  logic [BCNT_W-1:0] seg_a_q, seg_a_d;
  logic [BCNT_W-1:0] seg_b_q, seg_b_d;
  logic              acc_q, acc_d;
  logic [BCNT_W-1:0] moved_q, moved_d;
  logic [DATA_W-1:0] din_q, din_d;

  logic              take;
  logic              cfg_wr;
  logic              count_ok;
  logic              put_ok;
  logic              get_ok;
  logic [CNT_W-1:0]  n_c;
  logic [ADDR_W-1:0] ptr;
  logic [CNT_W-1:0]  to_end;
  logic [CNT_W-1:0]  adv;

  brf_seg_t                seg;
  brf_rd_t [NUM_LANES-1:0] lane_rd;

  assign take        = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  // a command offered in the same cycle goes first, so no transaction is dropped
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // admission check, done on the cycle the transaction is taken
  assign n_c      = CNT_W'(byte_count_i);
  assign count_ok = (byte_count_i != '0) && (32'(byte_count_i) <= MAX_BURST);
  assign put_ok   = (cmd_i == CMD_PUT) && count_ok && (n_c <= size_q - used_q);
  assign get_ok   = (cmd_i == CMD_GET) && count_ok && (n_c <= used_q);
  assign ptr      = (cmd_i == CMD_PUT) ? wr_ptr_q : rd_ptr_q;
  // slots left before the wrap point, at least one
  assign to_end   = size_q - CNT_W'(ptr);

  always_comb begin
    adv = CNT_W'(ptr) + n_c;
    if (adv >= size_q) begin
      adv = adv - size_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    size_d     = size_q;
    used_d     = used_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    is_wr_d    = is_wr_q;
    is_rd_d    = is_rd_q;
    seg_base_d = seg_base_q;
    seg_a_d    = seg_a_q;
    seg_b_d    = seg_b_q;
    acc_d      = acc_q;
    moved_d    = moved_q;
    din_d      = din_q;

    case (state_q)
      ST_IDLE: begin
        if (cfg_wr) begin
          // a size change empties the ring like a flush
          size_d   = clamp_size(cfg_data_i);
          used_d   = '0;
          rd_ptr_d = '0;
          wr_ptr_d = '0;
        end else if (take) begin
          din_d      = data_in_i;
          is_wr_d    = put_ok;
          is_rd_d    = get_ok;
          seg_base_d = ptr;
          // split the burst at the wrap point into at most two runs
          seg_a_d    = (n_c < to_end) ? byte_count_i : BCNT_W'(to_end);
          seg_b_d    = (n_c < to_end) ? '0 : BCNT_W'(n_c - to_end);
          acc_d      = put_ok || get_ok || (cmd_i == CMD_FLUSH);
          moved_d    = (put_ok || get_ok) ? byte_count_i : '0;
          if (put_ok) begin
            wr_ptr_d = adv[ADDR_W-1:0];
            used_d   = used_q + n_c;
            state_d  = ST_SEG_A;
          end else if (get_ok) begin
            rd_ptr_d = adv[ADDR_W-1:0];
            used_d   = used_q - n_c;
            state_d  = ST_SEG_A;
          end else begin
            if (cmd_i == CMD_FLUSH) begin
              used_d   = '0;
              rd_ptr_d = '0;
              wr_ptr_d = '0;
            end
            state_d = ST_RESP;
          end
        end
      end
      ST_SEG_A: begin
        state_d = (seg_b_q != '0) ? ST_SEG_B : ST_DRAIN;
      end
      ST_SEG_B: begin
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      size_q   <= CNT_W'(DEPTH);
      used_q   <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      is_wr_q  <= 1'b0;
      is_rd_q  <= 1'b0;
      acc_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      size_q   <= size_d;
      used_q   <= used_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      is_wr_q  <= is_wr_d;
      is_rd_q  <= is_rd_d;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_base_q <= seg_base_d;
    seg_a_q    <= seg_a_d;
    seg_b_q    <= seg_b_d;
    moved_q    <= moved_d;
    din_q      <= din_d;
  end

  // run presented to all lanes: first run from the pointer, second from slot zero
  always_comb begin
    seg.wr   = is_wr_q && ((state_q == ST_SEG_A) || (state_q == ST_SEG_B));
    seg.rd   = is_rd_q && ((state_q == ST_SEG_A) || (state_q == ST_SEG_B));
    seg.base = (state_q == ST_SEG_B) ? '0 : seg_base_q;
    seg.len  = (state_q == ST_SEG_B) ? seg_b_q : seg_a_q;
    seg.off  = (state_q == ST_SEG_B) ? seg_a_q[LANE_W-1:0] : '0;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    brf_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .lane_id_i (LANE_W'(l)),
      .seg_i     (seg),
      .data_i    (din_q),
      .rd_o      (lane_rd[l])
    );
  end

  // gathers read bytes; cleared when a new transaction is taken
  brf_merge u_merge (
    .clk_i  (clk_i),
    .clr_i  (take && !cfg_wr),
    .rd_i   (lane_rd),
    .data_o (data_out_o)
  );

  // result fields, fill state as it stands after the transaction
  assign result_valid_o = (state_q == ST_RESP);
  assign accepted_o     = acc_q;
  assign moved_count_o  = moved_q;
  assign used_bytes_o   = SIZE_W'(used_q);
  assign free_bytes_o   = SIZE_W'(size_q - used_q);
  assign is_empty_o     = (used_q == '0);
  assign is_full_o      = (used_q == size_q);

  `BRF_ASSERT_NEVER(a_used_le_size, clk_i, rst_ni, used_q > size_q)
  `BRF_ASSERT(a_take_then_busy, clk_i, rst_ni, take && !cfg_wr |=> busy)
  `BRF_ASSERT(a_refused_moves_nothing, clk_i, rst_ni,
              result_valid_o && !accepted_o |-> moved_count_o == '0 && data_out_o == '0)
  `BRF_ASSERT_NEVER(a_runs_within_burst, clk_i, rst_ni,
                    busy && (is_wr_q || is_rd_q) &&
                    (32'(seg_a_q) + 32'(seg_b_q) > MAX_BURST))

endmodule
